[sv/skt_pkg.sv]
// skt_pkg: shared types and constants for the sorted key table.
// Command and status codes, controller states, result record.
// No dependencies.
package skt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int PAY_W        = 32;
    localparam int POS_W        = 6;
    localparam int CNT_W        = 7;
    localparam int ENTRY_W      = KEY_W + PAY_W;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_REPLACE = 3'd3,
        CMD_LOOKUP  = 3'd4,
        CMD_READ    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_CHK,
        S_SHIFT,
        S_FIN,
        S_RDIDX
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [KEY_W-1:0]   found_key;
        logic [PAY_W-1:0]   found_payload;
        logic [POS_W-1:0]   found_position;
        logic [CNT_W-1:0]   entry_count;
    } t_result;

endpackage

[sv/skt_mem.sv]
// skt_mem: entry store, one write port and one read port with registered read data.
// Holds {key, payload} per entry. Depends on nothing.
module skt_mem #(
    parameter int DEPTH = 64,
    parameter int DW    = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/skt_ctrl.sv]
// skt_ctrl: command sequencer for the sorted key table.
// Binary search, entry shifting and result formation over skt_mem; uses skt_pkg.
module skt_ctrl #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_command,
    input  logic [skt_pkg::KEY_W-1:0]   i_key,
    input  logic [skt_pkg::PAY_W-1:0]   i_payload,
    input  logic [skt_pkg::POS_W-1:0]   i_position,
    output logic                        o_mem_we,
    output logic [$clog2(CAPACITY)-1:0] o_mem_waddr,
    output logic [skt_pkg::ENTRY_W-1:0] o_mem_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_mem_raddr,
    input  logic [skt_pkg::ENTRY_W-1:0] i_mem_rdata,
    output logic                        o_res_valid,
    output skt_pkg::t_result            o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = skt_pkg::KEY_W;
    localparam int PW = skt_pkg::PAY_W;
    localparam int QW = skt_pkg::POS_W;

    skt_pkg::t_state  r_state, n_state;
    logic [2:0]       r_cmd, n_cmd;
    logic [KW-1:0]    r_key, n_key;
    logic [PW-1:0]    r_pay, n_pay;
    logic [QW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_dpay, n_dpay;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_mid, n_mid;
    logic [CW-1:0]    r_left, n_left;
    logic [AW-1:0]    r_rd_addr, n_rd_addr;
    logic [AW-1:0]    r_wr_addr, n_wr_addr;
    logic             r_wr_pend, n_wr_pend;
    logic             r_strobe, n_strobe;
    skt_pkg::t_result r_res, n_res;

    logic             w_acc;
    logic             w_full;
    logic             w_range;
    logic             w_lt;
    logic [CW-1:0]    w_mid;
    logic [KW-1:0]    w_rd_key;
    logic [PW-1:0]    w_rd_pay;
    logic             w_right;
    logic             w_miss;
    logic             w_ins;
    logic             w_del;
    logic             w_fin;

    assign w_acc    = start && (r_state == skt_pkg::S_IDLE);
    assign w_full   = r_count >= CW'(CAPACITY);
    assign w_range  = {{CW{1'b0}}, i_position} >= {{QW{1'b0}}, r_count};
    assign w_lt     = r_lo < r_hi;
    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_rd_key = i_mem_rdata[skt_pkg::ENTRY_W-1:PW];
    assign w_rd_pay = i_mem_rdata[PW-1:0];
    assign w_ins    = (r_cmd == skt_pkg::CMD_INSERT);
    assign w_del    = (r_cmd == skt_pkg::CMD_DELETE);
    // insert searches past equal keys, the others stop at the first equal key
    assign w_right  = (w_rd_key < r_key) || (w_ins && (w_rd_key == r_key));
    assign w_miss   = r_lo >= r_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            skt_pkg::S_IDLE: begin
                if (w_acc) begin
                    case (i_command)
                        skt_pkg::CMD_INSERT: begin
                            n_state = w_full ? skt_pkg::S_IDLE : skt_pkg::S_SRCH;
                        end
                        skt_pkg::CMD_DELETE, skt_pkg::CMD_REPLACE, skt_pkg::CMD_LOOKUP: begin
                            n_state = skt_pkg::S_SRCH;
                        end
                        skt_pkg::CMD_READ: begin
                            n_state = w_range ? skt_pkg::S_IDLE : skt_pkg::S_RDIDX;
                        end
                        default: begin
                            n_state = skt_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            skt_pkg::S_SRCH: begin
                if (w_lt) begin
                    n_state = skt_pkg::S_CMP;
                end else if (w_ins) begin
                    n_state = skt_pkg::S_SHIFT;
                end else if (w_miss) begin
                    n_state = skt_pkg::S_IDLE;
                end else begin
                    n_state = skt_pkg::S_CHK;
                end
            end
            skt_pkg::S_CMP: begin
                n_state = skt_pkg::S_SRCH;
            end
            skt_pkg::S_CHK: begin
                if (w_rd_key == r_key && w_del) begin
                    n_state = skt_pkg::S_SHIFT;
                end else begin
                    n_state = skt_pkg::S_IDLE;
                end
            end
            skt_pkg::S_SHIFT: begin
                if (r_left == '0 && !r_wr_pend) begin
                    n_state = skt_pkg::S_FIN;
                end
            end
            skt_pkg::S_FIN: begin
                n_state = skt_pkg::S_IDLE;
            end
            skt_pkg::S_RDIDX: begin
                n_state = skt_pkg::S_IDLE;
            end
            default: begin
                n_state = skt_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, memory ports and result
    always_comb begin
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_pay       = r_pay;
        n_pos       = r_pos;
        n_dpay      = r_dpay;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_left      = r_left;
        n_rd_addr   = r_rd_addr;
        n_wr_addr   = r_wr_addr;
        n_wr_pend   = r_wr_pend;
        n_res       = r_res;
        w_fin       = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(r_lo);
        o_mem_wdata = {r_key, r_pay};
        o_mem_raddr = AW'(w_mid);

        case (r_state)
            skt_pkg::S_IDLE: begin
                o_mem_raddr = AW'(i_position);
                if (w_acc) begin
                    n_cmd = i_command;
                    n_key = i_key;
                    n_pay = i_payload;
                    n_pos = i_position;
                    n_lo  = '0;
                    n_hi  = r_count;
                    n_res = '{skt_pkg::ST_OK, '0, '0, '0, '0};
                    case (i_command)
                        skt_pkg::CMD_CLEAR: begin
                            n_count = '0;
                            w_fin   = 1'b1;
                        end
                        skt_pkg::CMD_INSERT: begin
                            if (w_full) begin
                                n_res.status = skt_pkg::ST_FULL;
                                w_fin        = 1'b1;
                            end
                        end
                        skt_pkg::CMD_DELETE, skt_pkg::CMD_REPLACE, skt_pkg::CMD_LOOKUP: begin
                        end
                        skt_pkg::CMD_READ: begin
                            if (w_range) begin
                                n_res.status = skt_pkg::ST_RANGE;
                                w_fin        = 1'b1;
                            end
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            skt_pkg::S_SRCH: begin
                if (w_lt) begin
                    n_mid = w_mid;
                end else if (w_ins) begin
                    // move entries [lo, count) up by one, highest first
                    n_left    = r_count - r_lo;
                    n_rd_addr = AW'(r_count - CW'(1));
                    n_wr_pend = 1'b0;
                end else if (w_miss) begin
                    n_res.status = skt_pkg::ST_NOT_FOUND;
                    w_fin        = 1'b1;
                end else begin
                    o_mem_raddr = AW'(r_lo);
                end
            end
            skt_pkg::S_CMP: begin
                if (w_right) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
            end
            skt_pkg::S_CHK: begin
                if (w_rd_key != r_key) begin
                    n_res.status = skt_pkg::ST_NOT_FOUND;
                    w_fin        = 1'b1;
                end else if (w_del) begin
                    // move entries (lo, count) down by one, lowest first
                    n_dpay    = w_rd_pay;
                    n_left    = r_count - CW'(1) - r_lo;
                    n_rd_addr = AW'(r_lo + CW'(1));
                    n_wr_pend = 1'b0;
                end else begin
                    n_res.found_key      = r_key;
                    n_res.found_payload  = w_rd_pay;
                    n_res.found_position = QW'(r_lo);
                    w_fin                = 1'b1;
                    if (r_cmd == skt_pkg::CMD_REPLACE) begin
                        o_mem_we            = 1'b1;
                        n_res.found_payload = r_pay;
                    end
                end
            end
            skt_pkg::S_SHIFT: begin
                o_mem_raddr = r_rd_addr;
                if (r_wr_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_wr_addr;
                    o_mem_wdata = i_mem_rdata;
                end
                if (r_left != '0) begin
                    n_left    = r_left - CW'(1);
                    n_wr_pend = 1'b1;
                    if (w_del) begin
                        n_rd_addr = r_rd_addr + AW'(1);
                        n_wr_addr = r_rd_addr - AW'(1);
                    end else begin
                        n_rd_addr = r_rd_addr - AW'(1);
                        n_wr_addr = r_rd_addr + AW'(1);
                    end
                end else begin
                    n_wr_pend = 1'b0;
                end
            end
            skt_pkg::S_FIN: begin
                n_res.found_key      = r_key;
                n_res.found_position = QW'(r_lo);
                w_fin                = 1'b1;
                if (w_del) begin
                    n_count             = r_count - CW'(1);
                    n_res.found_payload = r_dpay;
                end else begin
                    o_mem_we            = 1'b1;
                    n_count             = r_count + CW'(1);
                    n_res.found_payload = r_pay;
                end
            end
            skt_pkg::S_RDIDX: begin
                n_res.found_key      = w_rd_key;
                n_res.found_payload  = w_rd_pay;
                n_res.found_position = r_pos;
                w_fin                = 1'b1;
            end
            default: begin
            end
        endcase

        n_strobe = w_fin;
        if (w_fin) begin
            n_res.entry_count = skt_pkg::CNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= skt_pkg::S_IDLE;
            r_count   <= '0;
            r_strobe  <= 1'b0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_strobe  <= n_strobe;
            r_wr_pend <= n_wr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_pay     <= n_pay;
        r_pos     <= n_pos;
        r_dpay    <= n_dpay;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_left    <= n_left;
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        r_res     <= n_res;
    end

    assign busy        = (r_state != skt_pkg::S_IDLE);
    assign o_res_valid = r_strobe;
    assign o_res       = r_res;

endmodule

[sv/sorted_key_table_unit.sv]
// sorted_key_table_unit: top level of the sorted key table.
// Ties skt_ctrl to the skt_mem entry store; uses skt_pkg.
//
//   channel   handshake            fields
//   command   start / busy         i_command, i_key, i_payload, i_position
//   result    o_strobe (1 cycle)   o_status, o_found_key, o_found_payload,
//                                  o_found_position, o_entry_count
//
// Clear, full insert, out-of-range read, unknown: result formed at accept; read at index:
// formed in S_RDIDX. Search: each halving step runs S_SRCH then S_CMP, up to
// ceil(log2(count+1)) steps. Lookup/replace/delete check the key in S_CHK (a miss past the
// end skips it); insert and a found delete shift entries in S_SHIFT, then finish in S_FIN.
// Reset clears the count and the controller; entries hold garbage until written.
// The result shows for one cycle after the last step; the receiver cannot stall.
module sorted_key_table_unit #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          i_command,
    input  logic [skt_pkg::KEY_W-1:0]           i_key,
    input  logic [skt_pkg::PAY_W-1:0]           i_payload,
    input  logic [skt_pkg::POS_W-1:0]           i_position,
    output logic                                o_strobe,
    output logic [1:0]                          o_status,
    output logic [skt_pkg::KEY_W-1:0]           o_found_key,
    output logic [skt_pkg::PAY_W-1:0]           o_found_payload,
    output logic [skt_pkg::POS_W-1:0]           o_found_position,
    output logic [skt_pkg::CNT_W-1:0]           o_entry_count
);

    localparam int AW = $clog2(CAPACITY);

    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [skt_pkg::ENTRY_W-1:0] w_wdata;
    logic [AW-1:0]               w_raddr;
    logic [skt_pkg::ENTRY_W-1:0] w_rdata;
    skt_pkg::t_result            w_res;

    skt_mem #(
        .DEPTH (CAPACITY),
        .DW    (skt_pkg::ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    skt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_key       (i_key),
        .i_payload   (i_payload),
        .i_position  (i_position),
        .o_mem_we    (w_we),
        .o_mem_waddr (w_waddr),
        .o_mem_wdata (w_wdata),
        .o_mem_raddr (w_raddr),
        .i_mem_rdata (w_rdata),
        .o_res_valid (o_strobe),
        .o_res       (w_res)
    );

    assign o_status         = w_res.status;
    assign o_found_key      = w_res.found_key;
    assign o_found_payload  = w_res.found_payload;
    assign o_found_position = w_res.found_position;
    assign o_entry_count    = w_res.entry_count;

endmodule
